@@ design/gtae_pkg.sv @@
// shared types, constants and glyph mapping for the gray to ascii edge mapper
package gtae_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int PIX_W   = 8;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int WID_W   = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W   = 12;
	localparam int HGT_W   = 13;
	localparam int STYLE_W = 3;
	localparam int GLYPH_W = 7;
	localparam int GCOL_W  = 10;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_WID_W  = 11;

	localparam int OUT_FIELDS_W = GLYPH_W + GCOL_W + ROW_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [CFG_IDX_W-1:0] REG_STYLE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

	localparam logic [STYLE_W-1:0] STYLE_CLASSIC  = 3'd0;
	localparam logic [STYLE_W-1:0] STYLE_INVERSE  = 3'd1;
	localparam logic [STYLE_W-1:0] STYLE_X_EDGE   = 3'd2;
	localparam logic [STYLE_W-1:0] STYLE_Y_EDGE   = 3'd3;
	localparam logic [STYLE_W-1:0] STYLE_GRADIENT = 3'd4;

	localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd50;
	localparam logic [PIX_W-1:0] PIX_FULL        = 8'd255;
	localparam logic [3:0]       INV_BASE        = 4'd14;

	// v / 17 for 8-bit v as (v * 241) >> 12
	localparam logic [15:0] RAMP_MUL   = 16'd241;
	localparam int          RAMP_SHIFT = 12;

	localparam logic [GLYPH_W-1:0] CH_BLANK = 7'h20;
	localparam logic [GLYPH_W-1:0] CH_AT    = 7'h40;
	localparam logic [GLYPH_W-1:0] CH_AMP   = 7'h26;
	localparam logic [GLYPH_W-1:0] CH_PCT   = 7'h25;
	localparam logic [GLYPH_W-1:0] CH_W     = 7'h57;
	localparam logic [GLYPH_W-1:0] CH_X     = 7'h58;
	localparam logic [GLYPH_W-1:0] CH_A     = 7'h41;
	localparam logic [GLYPH_W-1:0] CH_H     = 7'h48;
	localparam logic [GLYPH_W-1:0] CH_O     = 7'h4F;
	localparam logic [GLYPH_W-1:0] CH_T     = 7'h54;
	localparam logic [GLYPH_W-1:0] CH_STAR  = 7'h2A;
	localparam logic [GLYPH_W-1:0] CH_CARET = 7'h5E;
	localparam logic [GLYPH_W-1:0] CH_PLUS  = 7'h2B;
	localparam logic [GLYPH_W-1:0] CH_DASH  = 7'h2D;
	localparam logic [GLYPH_W-1:0] CH_DOT   = 7'h2E;
	localparam logic [GLYPH_W-1:0] CH_BAR   = 7'h7C;

	typedef struct packed {
		logic [STYLE_W-1:0] style;
		logic [WID_W-1:0]   width;
		logic [HGT_W-1:0]   height;
		logic [PIX_W-1:0]   threshold;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             has_r;
		logic             last_row;
		logic             fwd;
	} pix_ctx_t;

	function automatic logic [GLYPH_W-1:0] ramp_char(input logic [3:0] idx);
		logic [GLYPH_W-1:0] ch;
		case (idx)
			4'd0:    ch = CH_AT;
			4'd1:    ch = CH_AMP;
			4'd2:    ch = CH_PCT;
			4'd3:    ch = CH_W;
			4'd4:    ch = CH_X;
			4'd5:    ch = CH_A;
			4'd6:    ch = CH_H;
			4'd7:    ch = CH_O;
			4'd8:    ch = CH_T;
			4'd9:    ch = CH_STAR;
			4'd10:   ch = CH_CARET;
			4'd11:   ch = CH_PLUS;
			4'd12:   ch = CH_DASH;
			4'd13:   ch = CH_DOT;
			default: ch = CH_BLANK;
		endcase
		return ch;
	endfunction

	function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [GLYPH_W-1:0] map_glyph(input logic [STYLE_W-1:0] style,
		input logic [PIX_W-1:0] thr, input logic [PIX_W-1:0] v, input logic has_r,
		input logic [PIX_W-1:0] rv, input logic has_d, input logic [PIX_W-1:0] dv);
		logic [PIX_W-1:0]   dx;
		logic [PIX_W-1:0]   dy;
		logic               ex;
		logic               ey;
		logic [15:0]        prod;
		logic [3:0]         q;
		logic [GLYPH_W-1:0] ch;
		dx   = has_r ? abs_diff(v, rv) : '0;
		dy   = has_d ? abs_diff(v, dv) : '0;
		ex   = dx >= thr;
		ey   = dy >= thr;
		prod = 16'(v) * RAMP_MUL;
		q    = prod[RAMP_SHIFT +: 4];
		case (style)
			STYLE_CLASSIC:  ch = ramp_char(q);
			STYLE_INVERSE:  ch = (v == PIX_FULL) ? CH_AT : ramp_char(INV_BASE - q);
			STYLE_X_EDGE:   ch = (has_r && ex) ? CH_BAR : CH_BLANK;
			STYLE_Y_EDGE:   ch = (has_d && ey) ? CH_DASH : CH_BLANK;
			STYLE_GRADIENT: ch = (ex && ey) ? CH_PLUS : ex ? CH_BAR : ey ? CH_DASH : CH_BLANK;
			default:        ch = CH_BLANK;
		endcase
		return ch;
	endfunction

endpackage

@@ design/gtae_ram.sv @@
// generic single-write, single-read ram with registered read data
module gtae_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ design/gtae_cfg_regs.sv @@
// configuration registers with width and height clamping
module gtae_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [gtae_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gtae_pkg::CFG_DATA_W-1:0]     cfg_data,
	output gtae_pkg::cfg_t                      cfg
);

	gtae_pkg::cfg_t                        cfg_q;
	logic [gtae_pkg::CFG_WID_W-1:0]        raw_w;
	logic [gtae_pkg::HGT_W-1:0]            raw_h;
	logic [gtae_pkg::WID_W-1:0]            eff_w;
	logic [gtae_pkg::HGT_W-1:0]            eff_h;

	assign raw_w = cfg_data[gtae_pkg::CFG_WID_W-1:0];
	assign raw_h = cfg_data[gtae_pkg::HGT_W-1:0];

	always_comb begin
		if (raw_w == '0) begin
			eff_w = gtae_pkg::WID_W'(1);
		end else if (int'(raw_w) > gtae_pkg::MAX_WIDTH) begin
			eff_w = gtae_pkg::WID_W'(gtae_pkg::MAX_WIDTH);
		end else begin
			eff_w = gtae_pkg::WID_W'(raw_w);
		end
		if (raw_h == '0) begin
			eff_h = gtae_pkg::HGT_W'(1);
		end else if (int'(raw_h) > gtae_pkg::MAX_HEIGHT) begin
			eff_h = gtae_pkg::HGT_W'(gtae_pkg::MAX_HEIGHT);
		end else begin
			eff_h = raw_h;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.style     <= gtae_pkg::STYLE_CLASSIC;
			cfg_q.width     <= gtae_pkg::WID_W'((gtae_pkg::MAX_WIDTH < 1024) ?
				gtae_pkg::MAX_WIDTH : 1024);
			cfg_q.height    <= gtae_pkg::HGT_W'(gtae_pkg::MAX_HEIGHT);
			cfg_q.threshold <= gtae_pkg::THRESHOLD_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				gtae_pkg::REG_STYLE:     cfg_q.style     <= cfg_data[gtae_pkg::STYLE_W-1:0];
				gtae_pkg::REG_WIDTH:     cfg_q.width     <= eff_w;
				gtae_pkg::REG_HEIGHT:    cfg_q.height    <= eff_h;
				gtae_pkg::REG_THRESHOLD: cfg_q.threshold <= cfg_data[gtae_pkg::PIX_W-1:0];
				default:                 cfg_q           <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/gtae_emit.sv @@
// glyph stage: neighbor assembly, glyph mapping and output register
module gtae_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              restart,
	input  gtae_pkg::cfg_t                    cfg,
	input  logic                              load,
	input  gtae_pkg::pix_ctx_t                ld_ctx,
	input  logic [gtae_pkg::PIX_W-1:0]        rd_data,
	output logic                              free,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [gtae_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast
);

	gtae_pkg::pix_ctx_t                ctx_s1;
	logic                              valid_s1;
	logic [2:0]                        pend_s1;
	logic [gtae_pkg::PIX_W-1:0]        up_q;
	logic [gtae_pkg::PIX_W-1:0]        left_q;
	logic                              out_valid_q;
	logic [gtae_pkg::OUT_DATA_W-1:0]   out_data_q;
	logic                              out_last_q;

	logic [gtae_pkg::PIX_W-1:0]        upr;
	logic [2:0]                        ld_pend;
	logic [2:0]                        sel;
	logic [2:0]                        pend_next;
	logic                              out_free;
	logic                              emit;
	logic                              retire;
	logic [gtae_pkg::GLYPH_W-1:0]      g_up;
	logic [gtae_pkg::GLYPH_W-1:0]      g_left;
	logic [gtae_pkg::GLYPH_W-1:0]      g_self;
	logic [gtae_pkg::GLYPH_W-1:0]      g_sel;
	logic [gtae_pkg::COL_W-1:0]        col_sel;
	logic [gtae_pkg::ROW_W-1:0]        row_sel;
	logic                              done_sel;

	// up to three glyphs per pixel: upper row, left neighbor, self at last corner
	assign ld_pend = {ld_ctx.last_row && !ld_ctx.has_r,
		ld_ctx.last_row && (ld_ctx.col != '0),
		ld_ctx.row != '0};

	assign upr = ctx_s1.fwd ? ctx_s1.pixel : rd_data;

	assign g_up = gtae_pkg::map_glyph(cfg.style, cfg.threshold, up_q, ctx_s1.has_r,
		upr, 1'b1, ctx_s1.pixel);
	assign g_left = gtae_pkg::map_glyph(cfg.style, cfg.threshold, left_q, 1'b1,
		ctx_s1.pixel, 1'b0, '0);
	assign g_self = gtae_pkg::map_glyph(cfg.style, cfg.threshold, ctx_s1.pixel, 1'b0,
		'0, 1'b0, '0);

	assign sel = pend_s1 & (~pend_s1 + 3'd1);

	always_comb begin
		g_sel    = g_self;
		col_sel  = ctx_s1.col;
		row_sel  = ctx_s1.row;
		done_sel = 1'b1;
		case (sel)
			3'b001: begin
				g_sel    = g_up;
				row_sel  = ctx_s1.row - gtae_pkg::ROW_W'(1);
				done_sel = 1'b0;
			end
			3'b010: begin
				g_sel    = g_left;
				col_sel  = ctx_s1.col - gtae_pkg::COL_W'(1);
				done_sel = 1'b0;
			end
			default: begin
				g_sel    = g_self;
				done_sel = 1'b1;
			end
		endcase
	end

	assign out_free  = !out_valid_q || m_tready;
	assign emit      = valid_s1 && (pend_s1 != '0) && out_free;
	assign pend_next = pend_s1 & ~sel;
	assign retire    = valid_s1 && ((pend_s1 == '0) || (emit && (pend_next == '0)));
	assign free      = !valid_s1 || retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pend_s1     <= '0;
			out_valid_q <= 1'b0;
			up_q        <= '0;
			left_q      <= '0;
		end else if (restart) begin
			valid_s1    <= 1'b0;
			pend_s1     <= '0;
			out_valid_q <= 1'b0;
			up_q        <= '0;
			left_q      <= '0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
				pend_s1  <= ld_pend;
			end else begin
				if (retire) begin
					valid_s1 <= 1'b0;
				end
				if (emit) begin
					pend_s1 <= pend_next;
				end
			end
			if (retire) begin
				up_q   <= upr;
				left_q <= ctx_s1.pixel;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctx_s1 <= ld_ctx;
		end
		if (emit) begin
			out_data_q <= gtae_pkg::OUT_DATA_W'({row_sel, gtae_pkg::GCOL_W'(col_sel), g_sel});
			out_last_q <= done_sel;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

@@ design/gray_to_ascii_edge_mapper.sv @@
// top level: raster counters, line buffer and glyph stage
//
// channel   dir  beat contents
// s_*       in   tdata[7:0] pixel
// m_*       out  tdata[6:0] glyph, [16:7] glyph_col, [28:17] glyph_row; tlast image_done
// cfg_*     in   write of register cfg_index (0 style, 1 width, 2 height, 3 threshold)
//
// one pixel per cycle while m_tready is high, last row aside; a released glyph passes the
// pixel register, then the output register. last-row pixels release up to three glyphs
// and hold s_tready low while the single output register drains one glyph per cycle
// line buffer: one ram, read of the next column and write of the current column each beat
// reset or any register write restarts the frame; no clearing pass is needed
module gray_to_ascii_edge_mapper (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [gtae_pkg::PIX_W-1:0]        s_tdata,     // pixel
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [gtae_pkg::OUT_DATA_W-1:0]   m_tdata,     // glyph, glyph_col, glyph_row, pad
	output logic                              m_tlast,
	input  logic                              cfg_wr_en,
	input  logic [gtae_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gtae_pkg::CFG_DATA_W-1:0]   cfg_data
);

	gtae_pkg::cfg_t                   cfg;
	gtae_pkg::pix_ctx_t               ld_ctx;
	logic [gtae_pkg::COL_W-1:0]       col_q;
	logic [gtae_pkg::ROW_W-1:0]       row_q;
	logic [gtae_pkg::COL_W-1:0]       rd_addr;
	logic [gtae_pkg::PIX_W-1:0]       rd_data;
	logic                             has_r;
	logic                             last_row;
	logic                             load;
	logic                             free;

	gtae_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign has_r    = (gtae_pkg::WID_W'(col_q) + gtae_pkg::WID_W'(1)) < cfg.width;
	assign last_row = gtae_pkg::HGT_W'(row_q) == (cfg.height - gtae_pkg::HGT_W'(1));
	assign rd_addr  = has_r ? (col_q + gtae_pkg::COL_W'(1)) : '0;
	assign load     = s_tvalid && s_tready;
	assign s_tready = free;

	assign ld_ctx.pixel    = s_tdata;
	assign ld_ctx.col      = col_q;
	assign ld_ctx.row      = row_q;
	assign ld_ctx.has_r    = has_r;
	assign ld_ctx.last_row = last_row;
	assign ld_ctx.fwd      = rd_addr == col_q;

	gtae_ram #(
		.DATA_W (gtae_pkg::PIX_W),
		.DEPTH  (gtae_pkg::MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.wr_en   (load),
		.wr_addr (col_q),
		.wr_data (s_tdata),
		.rd_en   (load),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr_en) begin
			col_q <= '0;
			row_q <= '0;
		end else if (load) begin
			if (has_r) begin
				col_q <= col_q + gtae_pkg::COL_W'(1);
			end else begin
				col_q <= '0;
				row_q <= last_row ? '0 : (row_q + gtae_pkg::ROW_W'(1));
			end
		end
	end

	gtae_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_wr_en),
		.cfg      (cfg),
		.load     (load),
		.ld_ctx   (ld_ctx),
		.rd_data  (rd_data),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ design/gtae_checker.sv @@
// port-level checks for the gray to ascii edge mapper, bound to the top level
module gtae_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [gtae_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                              m_tlast,
	input  logic                              cfg_wr_en
);

	// stalled beat keeps its valid
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && !cfg_wr_en |=> m_tvalid)
		else $error("output beat dropped while stalled");

	// stalled beat keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && !cfg_wr_en |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output payload changed while stalled");

	// glyph is always a printable character
	a_printable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:0] >= 7'h20) && (m_tdata[6:0] <= 7'h7C))
		else $error("glyph outside printable range");

	// pad bits above the row field stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[gtae_pkg::OUT_DATA_W-1:gtae_pkg::OUT_FIELDS_W] == '0))
		else $error("tdata pad bits set");

	// a register write flushes the output beat
	a_cfg_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> !m_tvalid)
		else $error("output beat survived a register write");

endmodule

bind gray_to_ascii_edge_mapper gtae_checker u_gtae_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.cfg_wr_en (cfg_wr_en)
);
